// ===== sv/dpfr_pkg.sv =====
// Types and constants shared by the demand page fault resolver.
package dpfr_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT  = 1'd1;

    localparam logic [4:0] PAGE_SHIFT_RESET = 5'd12;
    localparam logic [4:0] PAGE_SHIFT_MIN   = 5'd8;
    localparam logic [4:0] PAGE_SHIFT_MAX   = 5'd16;
    localparam logic [3:0] SEG_COUNT_RESET  = 4'd0;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FAULT = 1'b1;

    localparam logic [2:0] ST_LOADED    = 3'd0;
    localparam logic [2:0] ST_MAP       = 3'd1;
    localparam logic [2:0] ST_NOT_FAULT = 3'd2;
    localparam logic [2:0] ST_NO_SEG    = 3'd3;
    localparam logic [2:0] ST_MAPPED    = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  seg_slot;
        logic [31:0] seg_start;
        logic [31:0] seg_mem_bytes;
        logic [31:0] seg_file_bytes;
        logic [31:0] seg_file_offset;
        logic [2:0]  seg_access;
        logic [31:0] fault_address;
        logic        is_access_fault;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  page_number;
        logic [31:0] page_address;
        logic [31:0] page_file_offset;
        logic [31:0] zero_address;
        logic [31:0] zero_length;
        logic [2:0]  page_access;
    } t_out_item;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] mem_bytes;
        logic [31:0] file_bytes;
        logic [31:0] file_offset;
        logic [2:0]  access;
    } t_seg;

endpackage

// ===== sv/dpfr_stream_if.sv =====
// Valid/ready channel carrying one item.
interface dpfr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== sv/demand_page_fault_resolver.sv =====
// Demand page fault resolver: segment table search and page mark update.
//
//  channel  | dir | type        | carries
//  i_in     | in  | t_in_item   | segment load or fault to resolve
//  o_out    | out | t_out_item  | one result per accepted item
//  i_cfg_*  | in  | write port  | page_shift (0), segment_count (1)
//
// A load, a forwarded fault and a fault with no segment to search go straight to the
// result. Any other fault reads segment table entries in order, 1 to SEGMENTS of them,
// and ends in no match, a page out of range, an already mapped page or a newly mapped
// page; the segment table memory gives one entry a cycle. The page mark memory holds one
// row per slot with a reset-cleared valid bit per row, so no clearing pass follows reset.
// A new item is accepted while the previous result waits in the output register;
// a finished result stalls only while that register is still full.
module demand_page_fault_resolver #(
    parameter int SEGMENTS          = 8,
    parameter int PAGES_PER_SEGMENT = 256,
    parameter int ADDR_WIDTH        = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dpfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dpfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dpfr_stream_if.sink                    i_in,
    dpfr_stream_if.source                  o_out
);
    import dpfr_pkg::*;

    localparam int SW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CW   = $clog2(SEGMENTS + 1);
    localparam int PW   = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;
    localparam int AW_M = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam logic [32:0] AMASK_W = (33'd1 << AW_M) - 33'd1;
    localparam logic [31:0] AMASK   = AMASK_W[31:0];

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_PAGE   = 3'd2;
    localparam logic [2:0] S_MARK   = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    t_seg                         r_tab [SEGMENTS];
    t_seg                         r_tab_q;
    logic [PAGES_PER_SEGMENT-1:0] r_marks [SEGMENTS];
    logic [PAGES_PER_SEGMENT-1:0] r_row_q;
    logic                         r_row_v;
    logic [SEGMENTS-1:0]          r_row_valid;

    logic [4:0]      r_page_shift;
    logic [3:0]      r_seg_count;
    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_n, n_n;
    logic [31:0]     r_addr, n_addr;
    logic [SW-1:0]   r_slot, n_slot;
    t_seg            r_ent, n_ent;
    logic [31:0]     r_off, n_off;
    logic [4:0]      r_sh, n_sh;
    logic [PW-1:0]   r_page, n_page;
    logic [31:0]     r_pstart, n_pstart;
    logic [31:0]     r_pend, n_pend;
    logic            r_zfill, n_zfill;
    logic [31:0]     r_zs, n_zs;
    t_out_item       r_res, n_res;
    t_out_item       r_out;
    logic            r_out_valid;

    logic            in_fire;
    logic            is_load;
    logic            tab_we;
    logic [SW-1:0]   tab_wa;
    logic [SW-1:0]   tab_ra;
    logic [CW-1:0]   nxt_idx;
    logic [CW-1:0]   cnt_lim;
    logic [4:0]      sh_clamp;
    logic [31:0]     diff;
    logic            hit;
    logic [31:0]     pg_full;
    logic [31:0]     pg_mask;
    logic [PAGES_PER_SEGMENT-1:0] row;
    logic [PAGES_PER_SEGMENT-1:0] row_set;
    logic            mark_we;
    logic            out_load;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign is_load     = (i_in.item.opcode == OP_LOAD);
    assign tab_we      = in_fire && is_load && (int'(i_in.item.seg_slot) < SEGMENTS);
    assign tab_wa      = SW'(i_in.item.seg_slot);
    assign nxt_idx     = r_idx + CW'(1);
    assign tab_ra      = (r_state == S_SEARCH) ? nxt_idx[SW-1:0] : '0;
    assign cnt_lim     = (int'(r_seg_count) > SEGMENTS) ? CW'(SEGMENTS) : CW'(r_seg_count);
    assign sh_clamp    = (r_page_shift < PAGE_SHIFT_MIN) ? PAGE_SHIFT_MIN :
                         (r_page_shift > PAGE_SHIFT_MAX) ? PAGE_SHIFT_MAX : r_page_shift;
    assign diff        = r_addr - r_tab_q.start;
    assign hit         = (r_addr >= r_tab_q.start) && (diff < r_tab_q.mem_bytes);
    assign pg_full     = r_off >> r_sh;
    assign pg_mask     = (32'd1 << r_sh) - 32'd1;
    assign row         = r_row_v ? r_row_q : '0;
    assign mark_we     = (r_state == S_MARK) && !row[r_page];
    assign out_load    = (r_state == S_RESULT) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    always_comb begin
        row_set         = row;
        row_set[r_page] = 1'b1;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_n      = r_n;
        n_addr   = r_addr;
        n_slot   = r_slot;
        n_ent    = r_ent;
        n_off    = r_off;
        n_sh     = r_sh;
        n_page   = r_page;
        n_pstart = r_pstart;
        n_pend   = r_pend;
        n_zfill  = r_zfill;
        n_zs     = r_zs;
        n_res    = r_res;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res   = '0;
                    n_state = S_RESULT;
                    n_addr  = i_in.item.fault_address & AMASK;
                    n_idx   = '0;
                    n_n     = cnt_lim;
                    n_sh    = sh_clamp;
                    if (is_load) begin
                        n_res.status = ST_LOADED;
                    end else if (!i_in.item.is_access_fault) begin
                        n_res.status = ST_NOT_FAULT;
                    end else if (cnt_lim == '0) begin
                        n_res.status = ST_NO_SEG;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_off   = diff;
                    n_ent   = r_tab_q;
                    n_slot  = r_idx[SW-1:0];
                    n_state = S_PAGE;
                end else if (nxt_idx == r_n) begin
                    n_res.status = ST_NO_SEG;
                    n_state      = S_RESULT;
                end else begin
                    n_idx = nxt_idx;
                end
            end
            S_PAGE: begin
                n_page   = pg_full[PW-1:0];
                n_pstart = r_off & ~pg_mask;
                n_pend   = (r_off & ~pg_mask) + (32'd1 << r_sh);
                if (pg_full >= 32'(PAGES_PER_SEGMENT)) begin
                    n_res.status = ST_RANGE;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                n_zfill = (r_ent.file_bytes < r_ent.mem_bytes) && (r_pend > r_ent.file_bytes);
                n_zs    = (r_ent.file_bytes > r_pstart) ? r_ent.file_bytes : r_pstart;
                if (row[r_page]) begin
                    n_res.status      = ST_MAPPED;
                    n_res.page_number = 8'(r_page);
                    n_state           = S_RESULT;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_res.status           = ST_MAP;
                n_res.page_number      = 8'(r_page);
                n_res.page_address     = (r_ent.start + r_pstart) & AMASK;
                n_res.page_file_offset = r_ent.file_offset + r_pstart;
                n_res.zero_address     = r_zfill ? ((r_ent.start + r_zs) & AMASK) : '0;
                n_res.zero_length      = r_zfill ? (r_pend - r_zs) : '0;
                n_res.page_access      = r_ent.access;
                n_state                = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_wa] <= '{start:       i_in.item.seg_start,
                               mem_bytes:   i_in.item.seg_mem_bytes,
                               file_bytes:  i_in.item.seg_file_bytes,
                               file_offset: i_in.item.seg_file_offset,
                               access:      i_in.item.seg_access};
        end
        r_tab_q <= r_tab[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_marks[r_slot] <= row_set;
        end
        r_row_q <= r_marks[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_row_v     <= 1'b0;
        end else begin
            if (tab_we) begin
                r_row_valid[tab_wa] <= 1'b0;
            end else if (mark_we) begin
                r_row_valid[r_slot] <= 1'b1;
            end
            r_row_v <= r_row_valid[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= PAGE_SHIFT_RESET;
            r_seg_count  <= SEG_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PAGE_SHIFT) begin
                r_page_shift <= i_cfg_data;
            end else if (i_cfg_index == CFG_SEG_COUNT) begin
                r_seg_count <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_slot   <= n_slot;
        r_ent    <= n_ent;
        r_off    <= n_off;
        r_sh     <= n_sh;
        r_page   <= n_page;
        r_pstart <= n_pstart;
        r_pend   <= n_pend;
        r_zfill  <= n_zfill;
        r_zs     <= n_zs;
        r_res    <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx < r_n))
        else $error("search index beyond segment count");

    a_forward_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.item.opcode == OP_FAULT && !i_in.item.is_access_fault)
        |=> (r_state == S_RESULT && r_res.status == ST_NOT_FAULT))
        else $error("forwarded fault not reported as not fault");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.item.status <= ST_RANGE))
        else $error("illegal status code on output");

    a_mark_only_from_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mark_we |=> (r_state == S_FILL))
        else $error("page mark written without map result");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the demand page fault resolver: segment loads, fault resolution.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpfr_pkg::*;

    localparam int SEGMENTS = 8;
    localparam int PAGES    = 256;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dpfr_stream_if #(.T(t_in_item))  in_if ();
    dpfr_stream_if #(.T(t_out_item)) out_if ();

    demand_page_fault_resolver #(
        .SEGMENTS(SEGMENTS),
        .PAGES_PER_SEGMENT(PAGES),
        .ADDR_WIDTH(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in(in_if),
        .o_out(out_if)
    );

    always #10 i_clk = ~i_clk;

    t_in_item    pending_items[$];
    t_out_item   due_results[$];
    logic [31:0] fault_log[$];

    // predictor state
    t_seg             seg_tab[SEGMENTS];
    logic [PAGES-1:0] mark_tab[SEGMENTS];
    logic [4:0]       cur_shift;
    logic [3:0]       cur_count;

    // stimulus-side view of the segment table
    t_seg plan_seg[SEGMENTS];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int items_accepted;
    int results_checked;
    int status_seen[8];

    task automatic report_fail(string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_out_item resolve_item(t_in_item it);
        t_out_item   r;
        int          n;
        int          hit;
        int          sh;
        logic [31:0] off32;
        logic [63:0] pg;
        logic [63:0] pstart;
        logic [63:0] pend;
        logic [63:0] fb;
        logic [63:0] zs;
        r = '0;
        if (it.opcode == OP_LOAD) begin
            seg_tab[it.seg_slot] = '{start: it.seg_start, mem_bytes: it.seg_mem_bytes,
                                     file_bytes: it.seg_file_bytes,
                                     file_offset: it.seg_file_offset,
                                     access: it.seg_access};
            mark_tab[it.seg_slot] = '0;
            r.status = ST_LOADED;
            return r;
        end
        if (!it.is_access_fault) begin
            r.status = ST_NOT_FAULT;
            return r;
        end
        n = (cur_count > SEGMENTS) ? SEGMENTS : int'(cur_count);
        hit = -1;
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && it.fault_address >= seg_tab[i].start &&
                (it.fault_address - seg_tab[i].start) < seg_tab[i].mem_bytes)
                hit = i;
        end
        if (hit < 0) begin
            r.status = ST_NO_SEG;
            return r;
        end
        sh = (cur_shift < PAGE_SHIFT_MIN) ? int'(PAGE_SHIFT_MIN) :
             (cur_shift > PAGE_SHIFT_MAX) ? int'(PAGE_SHIFT_MAX) : int'(cur_shift);
        off32 = it.fault_address - seg_tab[hit].start;
        pg = 64'(off32) >> sh;
        if (pg >= PAGES) begin
            r.status = ST_RANGE;
            return r;
        end
        r.page_number = pg[7:0];
        if (mark_tab[hit][pg[7:0]]) begin
            r.status = ST_MAPPED;
            return r;
        end
        pstart = pg << sh;
        pend   = (pg + 1) << sh;
        fb     = 64'(seg_tab[hit].file_bytes);
        if (fb < 64'(seg_tab[hit].mem_bytes) && pend > fb) begin
            zs = (fb > pstart) ? fb : pstart;
            r.zero_address = seg_tab[hit].start + zs[31:0];
            r.zero_length  = 32'(pend - zs);
        end
        r.status           = ST_MAP;
        r.page_address     = seg_tab[hit].start + pstart[31:0];
        r.page_file_offset = seg_tab[hit].file_offset + pstart[31:0];
        r.page_access      = seg_tab[hit].access;
        mark_tab[hit][pg[7:0]] = 1'b1;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            cur_shift = PAGE_SHIFT_RESET;
            cur_count = SEG_COUNT_RESET;
            for (int i = 0; i < SEGMENTS; i++) begin
                seg_tab[i]  = '0;
                mark_tab[i] = '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PAGE_SHIFT)
                    cur_shift = i_cfg_data;
                else
                    cur_count = i_cfg_data[3:0];
            end
            if (in_if.valid && in_if.ready) begin
                due_results.push_back(resolve_item(in_if.item));
                items_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.item  <= pending_items.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = out_if.item;
                results_checked++;
                if (due_results.size() == 0) begin
                    report_fail($sformatf("unexpected result, status %0d", got.status));
                end else begin
                    want = due_results.pop_front();
                    status_seen[want.status]++;
                    if (got.status !== want.status)
                        report_fail($sformatf("status %h want %h", got.status, want.status));
                    if (got.page_number !== want.page_number)
                        report_fail($sformatf("page_number %h want %h",
                                              got.page_number, want.page_number));
                    if (got.page_address !== want.page_address)
                        report_fail($sformatf("page_address %h want %h",
                                              got.page_address, want.page_address));
                    if (got.page_file_offset !== want.page_file_offset)
                        report_fail($sformatf("page_file_offset %h want %h",
                                              got.page_file_offset, want.page_file_offset));
                    if (got.zero_address !== want.zero_address)
                        report_fail($sformatf("zero_address %h want %h",
                                              got.zero_address, want.zero_address));
                    if (got.zero_length !== want.zero_length)
                        report_fail($sformatf("zero_length %h want %h",
                                              got.zero_length, want.zero_length));
                    if (got.page_access !== want.page_access)
                        report_fail($sformatf("page_access %h want %h",
                                              got.page_access, want.page_access));
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in_item noise_item();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return t_in_item'(raw[167:0]);
    endfunction

    function automatic void push_item(t_in_item it);
        if (it.opcode == OP_LOAD)
            plan_seg[it.seg_slot] = '{start: it.seg_start, mem_bytes: it.seg_mem_bytes,
                                      file_bytes: it.seg_file_bytes,
                                      file_offset: it.seg_file_offset,
                                      access: it.seg_access};
        else if (it.is_access_fault) begin
            fault_log.push_back(it.fault_address);
            if (fault_log.size() > 32)
                void'(fault_log.pop_front());
        end
        pending_items.push_back(it);
    endfunction

    function automatic t_in_item load_item(logic [2:0] slot, logic [31:0] start,
                                           logic [31:0] mem, logic [31:0] file,
                                           logic [31:0] offset, logic [2:0] acc);
        t_in_item it;
        it = '0;
        it.opcode          = OP_LOAD;
        it.seg_slot        = slot;
        it.seg_start       = start;
        it.seg_mem_bytes   = mem;
        it.seg_file_bytes  = file;
        it.seg_file_offset = offset;
        it.seg_access      = acc;
        return it;
    endfunction

    function automatic t_in_item fault_item(logic [31:0] addr, logic access_fault);
        t_in_item it;
        it = '0;
        it.opcode          = OP_FAULT;
        it.fault_address   = addr;
        it.is_access_fault = access_fault;
        return it;
    endfunction

    function automatic t_in_item random_load(int sh);
        logic [31:0] mem;
        logic [31:0] file;
        int unsigned pages;
        case ($urandom_range(9))
            0: mem = '0;
            1: mem = $urandom;
            default: begin
                pages = $urandom_range(300, 1);
                mem = 32'(pages << sh) - $urandom_range((1 << sh) - 1);
            end
        endcase
        case ($urandom_range(7))
            0: file = '0;
            1: file = mem;
            2: file = $urandom;
            default: file = $urandom_range(mem);
        endcase
        return load_item(3'($urandom_range(7)), $urandom, mem, file, $urandom,
                         3'($urandom_range(7)));
    endfunction

    function automatic t_in_item random_fault(int n);
        t_in_item    it;
        int          slot;
        logic [31:0] addr;
        slot = (n == 0 || $urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(n - 1);
        if (plan_seg[slot].mem_bytes == 0)
            addr = $urandom;
        else
            addr = plan_seg[slot].start + $urandom_range(plan_seg[slot].mem_bytes - 1);
        it = noise_item();
        it.opcode          = OP_FAULT;
        it.fault_address   = addr;
        it.is_access_fault = 1'b1;
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        while ((pending_items.size() != 0 || due_results.size() != 0 || in_if.valid) &&
               guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (due_results.size() != 0) begin
            report_fail($sformatf("%0d results never arrived", due_results.size()));
            due_results.delete();
        end
    endtask

    task automatic run_phase(int shift_val, int count_val, int items, int send_pct,
                             int recv_pct);
        t_in_item it;
        int       sh;
        int       n;
        int       pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(shift_val));
        write_reg(CFG_SEG_COUNT, CFG_DATA_W'(count_val));
        sh = (shift_val < PAGE_SHIFT_MIN) ? int'(PAGE_SHIFT_MIN) :
             (shift_val > PAGE_SHIFT_MAX) ? int'(PAGE_SHIFT_MAX) : shift_val;
        n = (count_val > SEGMENTS) ? SEGMENTS : count_val;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                it = random_load(sh);
            end else if (pick < 80 || (pick < 88 && fault_log.size() == 0)) begin
                it = random_fault(n);
            end else if (pick < 88) begin
                it = noise_item();
                it.opcode          = OP_FAULT;
                it.is_access_fault = 1'b1;
                it.fault_address   = fault_log[$urandom_range(fault_log.size() - 1)];
            end else if (pick < 94) begin
                it = noise_item();
                it.opcode          = OP_FAULT;
                it.is_access_fault = 1'b0;
            end else begin
                it = noise_item();
            end
            push_item(it);
        end
        settle();
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.item    = '0;
        out_if.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 78;
        errors        = 0;
        for (int i = 0; i < SEGMENTS; i++)
            plan_seg[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // forwarded fault, then a fault while the segment count is zero, then segment loads
        push_item(fault_item(32'hFFFF_FFFF, 1'b0));
        push_item(fault_item(32'h0000_0000, 1'b1));
        push_item(load_item(3'd0, 32'h0001_0000, 32'h0000_5800, 32'h0000_2100,
                            32'h0000_1000, 3'd5));
        push_item(load_item(3'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                            32'h0000_0000, 3'd7));
        push_item(load_item(3'd2, 32'hFFFF_F000, 32'h0000_1000, 32'h0000_1000,
                            32'hFFFF_F800, 3'd3));
        push_item(load_item(3'd3, 32'h0040_0000, 32'h0020_0000, 32'h0020_0000,
                            32'h0000_0000, 3'd1));
        push_item(load_item(3'd4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h0000_8000, 3'd2));
        push_item(load_item(3'd5, 32'h0800_0000, 32'h0000_3000, 32'hFFFF_FFFF,
                            32'h0000_0123, 3'd4));
        push_item(load_item(3'd6, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                            32'hFFFF_FFFF, 3'd0));
        push_item(load_item(3'd7, 32'h1000_0000, 32'h0000_0001, 32'h0000_0000,
                            32'h0000_0040, 3'd6));
        settle();
        write_reg(CFG_SEG_COUNT, CFG_DATA_W'(SEGMENTS));
        write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(PAGE_SHIFT_RESET));
        push_item(fault_item(32'h0001_0000, 1'b1));
        push_item(fault_item(32'h0001_0FFF, 1'b1));
        push_item(fault_item(32'h0001_2345, 1'b1));
        push_item(fault_item(32'h0001_57FF, 1'b1));
        push_item(fault_item(32'h0001_5800, 1'b1));
        push_item(fault_item(32'hFFFF_FFFF, 1'b1));
        push_item(fault_item(32'h0060_0000, 1'b1));
        push_item(fault_item(32'h7FFF_FFFF, 1'b1));
        push_item(fault_item(32'h1000_0000, 1'b1));
        push_item(fault_item(32'h0800_2FFF, 1'b1));
        push_item(fault_item(32'h0000_0000, 1'b1));
        // reload clears the marks of the slot
        push_item(load_item(3'd0, 32'h0001_0000, 32'h0000_5800, 32'h0000_2100,
                            32'h0000_1000, 3'd5));
        push_item(fault_item(32'h0001_0000, 1'b1));
        settle();

        run_phase(8, 8, 230, 11, 78);
        run_phase(16, 15, 230, 11, 78);
        run_phase(0, 3, 230, 78, 11);
        run_phase(31, 8, 230, 78, 11);
        run_phase(12, 6, 230, 0, 0);
        run_phase(10, 8, 230, 0, 0);

        $display("tb_top: %0d items in, %0d results checked, %0d mismatches",
                 items_accepted, results_checked, errors);
        $display("tb_top: loaded %0d, mapped %0d, forwarded %0d, no segment %0d, %s %0d, %s %0d",
                 status_seen[ST_LOADED], status_seen[ST_MAP], status_seen[ST_NOT_FAULT],
                 status_seen[ST_NO_SEG], "already mapped", status_seen[ST_MAPPED],
                 "out of range", status_seen[ST_RANGE]);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
